/* rtl/tfn_pkg.sv */
`timescale 1ns / 1ps
package tfn_pkg;

  // Fraction bits of the normal and of the result, and the perturbation format
  localparam int FRAC_BITS       = 14;
  localparam int PERT_FRAC       = 12;
  localparam int RSQRT_STEPS_DEF = 3;

  // Field and datapath widths
  localparam int N_W    = 16;                    // input and result fields
  localparam int T1_W   = N_W + 1;               // first tangent candidate
  localparam int OUT_W  = FRAC_BITS + 2;         // unit vector component
  localparam int CRS_W  = N_W + OUT_W;           // cross product term
  localparam int OW_W   = N_W + 1;               // 1 + w in Q4.12
  localparam int NW_W   = N_W + OW_W;            // n * (1 + w)
  localparam int SUM_W  = ((NW_W > CRS_W) ? NW_W : CRS_W) + 2;

  // Up vector switch: |nz| above 0.99
  localparam longint NZ_LIM = (longint'(99) << FRAC_BITS) / 100;

  // One in the perturbation format
  localparam logic signed [OW_W-1:0] ONE_PERT = OW_W'(1) << PERT_FRAC;

  // Reciprocal square root seeds, by the top four bits of the squared length
  localparam logic [15:0] SEED_TAB [16] = '{
    16'd65535, 16'd65535, 16'd65535, 16'd65535,
    16'd61788, 16'd55889, 16'd51411, 16'd47861,
    16'd44957, 16'd42525, 16'd40450, 16'd38651,
    16'd37073, 16'd35673, 16'd34421, 16'd33292
  };

  // Cycles through one normalizer
  function automatic int u3_lat(input int steps);
    return 7 + 4 * steps;
  endfunction

endpackage

/* rtl/tfn_unit3.sv */
`timescale 1ns / 1ps
// Pipelined 3-vector normalizer: one word per cycle while adv is high.
module tfn_unit3 #(
  parameter int IN_W  = tfn_pkg::T1_W,
  parameter int STEPS = tfn_pkg::RSQRT_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  logic                              in_vld,
  input  logic signed [IN_W-1:0]            in_x,
  input  logic signed [IN_W-1:0]            in_y,
  input  logic signed [IN_W-1:0]            in_z,
  output logic                              out_vld,
  output logic signed [tfn_pkg::OUT_W-1:0]  out_x,
  output logic signed [tfn_pkg::OUT_W-1:0]  out_y,
  output logic signed [tfn_pkg::OUT_W-1:0]  out_z,
  output logic                              out_zero
);
  import tfn_pkg::*;

  localparam int SA_W = $clog2(IN_W + 1);
  localparam int NSTG = 4 * STEPS;
  localparam int SH   = 62 - FRAC_BITS;
  localparam logic [63:0]      RND   = 64'd1 << (SH - 1);
  localparam logic [OUT_W-1:0] LIM   = OUT_W'(1) << FRAC_BITS;
  localparam logic [33:0]      THREE = 34'd3 << 30;

  typedef struct packed {
    logic [2:0]  neg;
    logic        zero;
    logic        s;
    logic [29:0] x;
    logic [30:0] mag0;
    logic [30:0] mag1;
    logic [30:0] mag2;
  } side_t;

  // Stage 1: magnitudes, signs and the largest magnitude
  logic [IN_W-1:0] ux [3];
  logic [IN_W-1:0] mag_c [3];
  logic [IN_W-1:0] max_c;
  logic [IN_W-1:0] mag1_r [3];
  logic [IN_W-1:0] max1_r;
  logic [2:0]      neg1_r;
  logic            vld1_r;

  always_comb begin
    ux[0] = in_x;
    ux[1] = in_y;
    ux[2] = in_z;
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = ux[i][IN_W-1] ? (~ux[i] + 1'b1) : ux[i];
    end
    max_c = mag_c[0];
    if (mag_c[1] > max_c) max_c = mag_c[1];
    if (mag_c[2] > max_c) max_c = mag_c[2];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) mag1_r[i] <= mag_c[i];
      max1_r <= max_c;
      neg1_r <= {ux[2][IN_W-1], ux[1][IN_W-1], ux[0][IN_W-1]};
    end
  end

  // Stage 2: leading one of the largest magnitude gives the shift
  logic [SA_W-1:0] sa_c;
  logic [IN_W-1:0] mag2_r [3];
  logic [SA_W-1:0] sa2_r;
  logic [2:0]      neg2_r;
  logic            zero2_r;
  logic            vld2_r;

  always_comb begin
    sa_c = '0;
    for (int i = 0; i < IN_W; i++) begin
      if (max1_r[i]) sa_c = SA_W'(i + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) mag2_r[i] <= mag1_r[i];
      sa2_r   <= sa_c;
      neg2_r  <= neg1_r;
      zero2_r <= (max1_r == '0);
    end
  end

  // Stage 3: shift all magnitudes so the largest sits in [2^30, 2^31)
  logic [IN_W+30:0] wide_c [3];
  logic [30:0]      mag3_r [3];
  logic [2:0]       neg3_r;
  logic             zero3_r;
  logic             vld3_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wide_c[i] = {mag2_r[i], 31'd0} >> sa2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) mag3_r[i] <= wide_c[i][30:0];
      neg3_r  <= neg2_r;
      zero3_r <= zero2_r;
    end
  end

  // Stage 4: squares
  logic [61:0] sq4_r [3];
  logic [30:0] mag4_r [3];
  logic [2:0]  neg4_r;
  logic        zero4_r;
  logic        vld4_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sq4_r[i]  <= 62'(mag3_r[i]) * 62'(mag3_r[i]);
        mag4_r[i] <= mag3_r[i];
      end
      neg4_r  <= neg3_r;
      zero4_r <= zero3_r;
    end
  end

  // Stage 5: squared length, scale step, seed and iteration operand
  logic [63:0] len_c;
  logic [63:0] len2_c;
  logic        s_c;
  side_t       side_c;
  logic [31:0] y5_r;
  side_t       sd_r [NSTG+1];
  logic        sdv_r [NSTG+1];
  logic [31:0] ychain [STEPS+1];

  always_comb begin
    len_c       = 64'(sq4_r[0]) + 64'(sq4_r[1]) + 64'(sq4_r[2]);
    s_c         = (len_c[63:62] == 2'b00);
    len2_c      = s_c ? {len_c[61:0], 2'b00} : len_c;
    side_c.neg  = neg4_r;
    side_c.zero = zero4_r;
    side_c.s    = s_c;
    side_c.x    = len2_c[63:34];
    side_c.mag0 = mag4_r[0];
    side_c.mag1 = mag4_r[1];
    side_c.mag2 = mag4_r[2];
  end

  // Carry side data alongside the iterations
  always_ff @(posedge clk) begin
    if (adv) begin
      y5_r     <= {1'b0, SEED_TAB[len2_c[63:60]], 15'd0};
      sd_r[0]  <= side_c;
      for (int j = 1; j <= NSTG; j++) sd_r[j] <= sd_r[j-1];
    end
  end

  assign ychain[0] = y5_r;

  // Newton steps on the reciprocal square root, four stages each
  for (genvar k = 0; k < STEPS; k++) begin : g_it
    logic [33:0] y2_r;
    logic [31:0] ya_r;
    logic [33:0] t_r;
    logic [31:0] yb_r;
    logic [31:0] f_r;
    logic [31:0] yc_r;
    logic [31:0] yd_r;
    logic [63:0] yy_c;
    logic [63:0] xt_c;
    logic [63:0] yf_c;
    logic [31:0] f_c;

    assign yy_c = 64'(ychain[k]) * 64'(ychain[k]);
    assign xt_c = 64'(sd_r[4*k+1].x) * 64'(y2_r);
    assign f_c  = (t_r >= THREE) ? '0 : 32'(THREE - t_r);
    assign yf_c = 64'(yc_r) * 64'(f_r);

    always_ff @(posedge clk) begin
      if (adv) begin
        y2_r <= yy_c[63:30];
        ya_r <= ychain[k];
        t_r  <= xt_c[63:30];
        yb_r <= ya_r;
        f_r  <= f_c;
        yc_r <= yb_r;
        yd_r <= yf_c[62:31];
      end
    end

    assign ychain[k+1] = yd_r;
  end

  // Stage 6: scale each magnitude by the reciprocal length
  logic [62:0] prod6_r [3];
  side_t       side6_r;
  logic        vld6_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      prod6_r[0] <= 63'(sd_r[NSTG].mag0) * 63'(ychain[STEPS]);
      prod6_r[1] <= 63'(sd_r[NSTG].mag1) * 63'(ychain[STEPS]);
      prod6_r[2] <= 63'(sd_r[NSTG].mag2) * 63'(ychain[STEPS]);
      side6_r    <= sd_r[NSTG];
    end
  end

  // Stage 7: round half up, saturate, restore sign, zero a degenerate vector
  logic [63:0]      p_c  [3];
  logic [63:0]      pr_c [3];
  logic [OUT_W-1:0] r_c  [3];
  logic [OUT_W-1:0] rc_c [3];
  logic [OUT_W-1:0] sv_c [3];
  logic [OUT_W-1:0] res_r [3];
  logic             zero7_r;
  logic             vld7_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p_c[i]  = side6_r.s ? {prod6_r[i], 1'b0} : {1'b0, prod6_r[i]};
      pr_c[i] = p_c[i] + RND;
      r_c[i]  = pr_c[i][63:SH];
      rc_c[i] = (r_c[i] > LIM) ? LIM : r_c[i];
      sv_c[i] = side6_r.neg[i] ? (~rc_c[i] + 1'b1) : rc_c[i];
      if (side6_r.zero) sv_c[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) res_r[i] <= sv_c[i];
      zero7_r <= side6_r.zero;
    end
  end

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
      for (int j = 0; j <= NSTG; j++) sdv_r[j] <= 1'b0;
      vld6_r <= 1'b0;
      vld7_r <= 1'b0;
    end else if (adv) begin
      vld1_r   <= in_vld;
      vld2_r   <= vld1_r;
      vld3_r   <= vld2_r;
      vld4_r   <= vld3_r;
      sdv_r[0] <= vld4_r;
      for (int j = 1; j <= NSTG; j++) sdv_r[j] <= sdv_r[j-1];
      vld6_r   <= sdv_r[NSTG];
      vld7_r   <= vld6_r;
    end
  end

  assign out_vld  = vld7_r;
  assign out_x    = res_r[0];
  assign out_y    = res_r[1];
  assign out_z    = res_r[2];
  assign out_zero = zero7_r;

endmodule

/* rtl/tangent_frame_normal_perturb_unit.sv */
`timescale 1ns / 1ps
// Channel   Ports                                            Direction
// input     in_valid, in_stall, in_normal_*, in_perturb_*   in (stall out)
// result    out_valid, out_stall, out_x/y/z, out_degenerate out (stall in)
//
// A word enters every cycle while in_stall is low; three normalizers sit in
// series, each with four stages per Newton step. Reset clears only valid
// bits, those of the output and skid registers too; nothing else is held.
// A stalled result waits in the output register; one more word is kept in a
// skid register, and while that is full the whole pipeline and in_stall hold.
module tangent_frame_normal_perturb_unit #(
  parameter int RSQRT_STEPS = tfn_pkg::RSQRT_STEPS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [tfn_pkg::N_W-1:0]  in_normal_x,
  input  logic signed [tfn_pkg::N_W-1:0]  in_normal_y,
  input  logic signed [tfn_pkg::N_W-1:0]  in_normal_z,
  input  logic signed [tfn_pkg::N_W-1:0]  in_perturb_u,
  input  logic signed [tfn_pkg::N_W-1:0]  in_perturb_v,
  input  logic signed [tfn_pkg::N_W-1:0]  in_perturb_w,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [tfn_pkg::N_W-1:0]  out_x,
  output logic signed [tfn_pkg::N_W-1:0]  out_y,
  output logic signed [tfn_pkg::N_W-1:0]  out_z,
  output logic                            out_degenerate
);
  import tfn_pkg::*;

  localparam int LAT = u3_lat(RSQRT_STEPS);

  typedef struct packed {
    logic signed [N_W-1:0] nx;
    logic signed [N_W-1:0] ny;
    logic signed [N_W-1:0] nz;
    logic signed [N_W-1:0] u;
    logic signed [N_W-1:0] v;
    logic signed [N_W-1:0] w;
  } item_t;

  typedef struct packed {
    item_t                   it;
    logic signed [OUT_W-1:0] pvx;
    logic signed [OUT_W-1:0] pvy;
    logic signed [OUT_W-1:0] pvz;
    logic                    bad;
  } carry_t;

  logic adv;
  logic skid_vld_r;

  assign adv      = !skid_vld_r;
  assign in_stall = skid_vld_r;

  // Capture the input word
  item_t item0_r;
  logic  vld0_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      item0_r.nx <= in_normal_x;
      item0_r.ny <= in_normal_y;
      item0_r.nz <= in_normal_z;
      item0_r.u  <= in_perturb_u;
      item0_r.v  <= in_perturb_v;
      item0_r.w  <= in_perturb_w;
    end
  end

  // Pick the up vector and form up x n (up = x) or n x up (up = z)
  logic                   up_x;
  logic signed [T1_W-1:0] nx1, ny1, nz1;
  logic signed [T1_W-1:0] t1x, t1y, t1z;

  always_comb begin
    nx1  = T1_W'(item0_r.nx);
    ny1  = T1_W'(item0_r.ny);
    nz1  = T1_W'(item0_r.nz);
    up_x = (longint'(item0_r.nz) > NZ_LIM) || (longint'(item0_r.nz) < -NZ_LIM);
    if (up_x) begin
      t1x = '0;
      t1y = -nz1;
      t1z = ny1;
    end else begin
      t1x = ny1;
      t1y = -nx1;
      t1z = '0;
    end
  end

  // Tangent pV
  logic                    vld_a;
  logic signed [OUT_W-1:0] pv_x, pv_y, pv_z;
  logic                    zero_a;

  tfn_unit3 #(.IN_W(T1_W), .STEPS(RSQRT_STEPS)) u_norm_pv (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (vld0_r),
    .in_x     (t1x),
    .in_y     (t1y),
    .in_z     (t1z),
    .out_vld  (vld_a),
    .out_x    (pv_x),
    .out_y    (pv_y),
    .out_z    (pv_z),
    .out_zero (zero_a)
  );

  item_t dla_r [LAT];

  always_ff @(posedge clk) begin
    if (adv) begin
      dla_r[0] <= item0_r;
      for (int j = 1; j < LAT; j++) dla_r[j] <= dla_r[j-1];
    end
  end

  // n x pV: products
  item_t                   item1_r;
  logic signed [OUT_W-1:0] pv1_r [3];
  logic signed [CRS_W-1:0] c1_r [6];
  logic                    bad1_r;
  logic                    vld1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      item1_r  <= dla_r[LAT-1];
      pv1_r[0] <= pv_x;
      pv1_r[1] <= pv_y;
      pv1_r[2] <= pv_z;
      bad1_r   <= zero_a;
      c1_r[0]  <= CRS_W'(dla_r[LAT-1].ny) * CRS_W'(pv_z);
      c1_r[1]  <= CRS_W'(dla_r[LAT-1].nz) * CRS_W'(pv_y);
      c1_r[2]  <= CRS_W'(dla_r[LAT-1].nz) * CRS_W'(pv_x);
      c1_r[3]  <= CRS_W'(dla_r[LAT-1].nx) * CRS_W'(pv_z);
      c1_r[4]  <= CRS_W'(dla_r[LAT-1].nx) * CRS_W'(pv_y);
      c1_r[5]  <= CRS_W'(dla_r[LAT-1].ny) * CRS_W'(pv_x);
    end
  end

  // n x pV: differences
  item_t                   item2_r;
  logic signed [OUT_W-1:0] pv2_r [3];
  logic signed [CRS_W-1:0] t2_r [3];
  logic                    bad2_r;
  logic                    vld2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      item2_r <= item1_r;
      for (int i = 0; i < 3; i++) pv2_r[i] <= pv1_r[i];
      bad2_r  <= bad1_r;
      t2_r[0] <= c1_r[0] - c1_r[1];
      t2_r[1] <= c1_r[2] - c1_r[3];
      t2_r[2] <= c1_r[4] - c1_r[5];
    end
  end

  // Bitangent pU
  logic                    vld_b;
  logic signed [OUT_W-1:0] pu_x, pu_y, pu_z;
  logic                    zero_b;
  carry_t                  carry2_c;

  tfn_unit3 #(.IN_W(CRS_W), .STEPS(RSQRT_STEPS)) u_norm_pu (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (vld2_r),
    .in_x     (t2_r[0]),
    .in_y     (t2_r[1]),
    .in_z     (t2_r[2]),
    .out_vld  (vld_b),
    .out_x    (pu_x),
    .out_y    (pu_y),
    .out_z    (pu_z),
    .out_zero (zero_b)
  );

  always_comb begin
    carry2_c.it  = item2_r;
    carry2_c.pvx = pv2_r[0];
    carry2_c.pvy = pv2_r[1];
    carry2_c.pvz = pv2_r[2];
    carry2_c.bad = bad2_r;
  end

  carry_t dlb_r [LAT];

  always_ff @(posedge clk) begin
    if (adv) begin
      dlb_r[0] <= carry2_c;
      for (int j = 1; j < LAT; j++) dlb_r[j] <= dlb_r[j-1];
    end
  end

  // Weighted terms of the perturbed normal
  carry_t                  cb;
  logic signed [OW_W-1:0]  one_w;
  logic signed [NW_W-1:0]  nw3_r [3];
  logic signed [CRS_W-1:0] puu3_r [3];
  logic signed [CRS_W-1:0] pvv3_r [3];
  logic                    bad3_r;
  logic                    vld3_r;

  assign cb    = dlb_r[LAT-1];
  assign one_w = OW_W'(cb.it.w) + ONE_PERT;

  always_ff @(posedge clk) begin
    if (adv) begin
      nw3_r[0]  <= NW_W'(cb.it.nx) * NW_W'(one_w);
      nw3_r[1]  <= NW_W'(cb.it.ny) * NW_W'(one_w);
      nw3_r[2]  <= NW_W'(cb.it.nz) * NW_W'(one_w);
      puu3_r[0] <= CRS_W'(pu_x) * CRS_W'(cb.it.u);
      puu3_r[1] <= CRS_W'(pu_y) * CRS_W'(cb.it.u);
      puu3_r[2] <= CRS_W'(pu_z) * CRS_W'(cb.it.u);
      pvv3_r[0] <= CRS_W'(cb.pvx) * CRS_W'(cb.it.v);
      pvv3_r[1] <= CRS_W'(cb.pvy) * CRS_W'(cb.it.v);
      pvv3_r[2] <= CRS_W'(cb.pvz) * CRS_W'(cb.it.v);
      bad3_r    <= cb.bad | zero_b;
    end
  end

  // Sum the terms
  logic signed [SUM_W-1:0] sum4_r [3];
  logic                    bad4_r;
  logic                    vld4_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sum4_r[i] <= SUM_W'(nw3_r[i]) + SUM_W'(puu3_r[i]) + SUM_W'(pvv3_r[i]);
      end
      bad4_r <= bad3_r;
    end
  end

  // Final normalize
  logic                    vld_c;
  logic signed [OUT_W-1:0] res_x, res_y, res_z;
  logic                    zero_c;

  tfn_unit3 #(.IN_W(SUM_W), .STEPS(RSQRT_STEPS)) u_norm_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (vld4_r),
    .in_x     (sum4_r[0]),
    .in_y     (sum4_r[1]),
    .in_z     (sum4_r[2]),
    .out_vld  (vld_c),
    .out_x    (res_x),
    .out_y    (res_y),
    .out_z    (res_z),
    .out_zero (zero_c)
  );

  logic dlc_r [LAT];

  always_ff @(posedge clk) begin
    if (adv) begin
      dlc_r[0] <= bad4_r;
      for (int j = 1; j < LAT; j++) dlc_r[j] <= dlc_r[j-1];
    end
  end

  // Drop the vector on any degenerate normalization
  logic                  deg_c;
  logic signed [N_W-1:0] fx_c, fy_c, fz_c;

  always_comb begin
    deg_c = dlc_r[LAT-1] | zero_c;
    fx_c  = deg_c ? '0 : N_W'(res_x);
    fy_c  = deg_c ? '0 : N_W'(res_y);
    fz_c  = deg_c ? '0 : N_W'(res_z);
  end

  // Advance valid bits of the glue stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
    end else if (adv) begin
      vld0_r <= in_valid;
      vld1_r <= vld_a;
      vld2_r <= vld1_r;
      vld3_r <= vld_b;
      vld4_r <= vld3_r;
    end
  end

  // Output register and skid register
  logic                  ov_r;
  logic signed [N_W-1:0] ox_r, oy_r, oz_r;
  logic                  odeg_r;
  logic signed [N_W-1:0] sx_r, sy_r, sz_r;
  logic                  sdeg_r;
  logic                  take;

  assign take = !ov_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r       <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (take) begin
      if (skid_vld_r) begin
        ov_r       <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        ov_r <= vld_c;
      end
    end else if (vld_c && adv) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (skid_vld_r) begin
        ox_r   <= sx_r;
        oy_r   <= sy_r;
        oz_r   <= sz_r;
        odeg_r <= sdeg_r;
      end else begin
        ox_r   <= fx_c;
        oy_r   <= fy_c;
        oz_r   <= fz_c;
        odeg_r <= deg_c;
      end
    end else if (vld_c && adv) begin
      sx_r   <= fx_c;
      sy_r   <= fy_c;
      sz_r   <= fz_c;
      sdeg_r <= deg_c;
    end
  end

  assign out_valid      = ov_r;
  assign out_x          = ox_r;
  assign out_y          = oy_r;
  assign out_z          = oz_r;
  assign out_degenerate = odeg_r;

endmodule

/* sim/tfn_checker.sv */
`timescale 1ns / 1ps
module tfn_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic signed [tfn_pkg::N_W-1:0] in_normal_x,
  input  logic signed [tfn_pkg::N_W-1:0] in_normal_y,
  input  logic signed [tfn_pkg::N_W-1:0] in_normal_z,
  input  logic signed [tfn_pkg::N_W-1:0] in_perturb_u,
  input  logic signed [tfn_pkg::N_W-1:0] in_perturb_v,
  input  logic signed [tfn_pkg::N_W-1:0] in_perturb_w,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic signed [tfn_pkg::N_W-1:0] out_x,
  input  logic signed [tfn_pkg::N_W-1:0] out_y,
  input  logic signed [tfn_pkg::N_W-1:0] out_z,
  input  logic                           out_degenerate,
  output int                             errors,
  output int                             pending
);
  import tfn_pkg::*;

  typedef struct packed {
    logic [15:0] x, y, z;
    logic        degen;
  } bent_normal_t;

  localparam int STEPS = 3;
  localparam logic [15:0] RS_SEED [16] = '{
    16'd65535, 16'd65535, 16'd65535, 16'd65535,
    16'd61788, 16'd55889, 16'd51411, 16'd47861,
    16'd44957, 16'd42525, 16'd40450, 16'd38651,
    16'd37073, 16'd35673, 16'd34421, 16'd33292
  };

  bent_normal_t bent_q[$];

  // Scale a vector to unit length; return 1 when it is the zero vector
  function automatic bit to_unit(input longint v[3], output longint o[3]);
    logic [63:0] mag[3];
    logic [63:0] m, len2, y, x, y2, t, f, p, r, lim;
    bit neg[3];
    int s;
    s = 0;
    m = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = v[i] < 0;
      mag[i] = neg[i] ? 64'(-v[i]) : 64'(v[i]);
      if (mag[i] > m) m = mag[i];
    end
    if (m == 0) begin
      for (int i = 0; i < 3; i++) o[i] = 0;
      return 1;
    end
    while (m >= 64'd1 << 31) begin
      m >>= 1;
      for (int i = 0; i < 3; i++) mag[i] >>= 1;
    end
    while (m < 64'd1 << 30) begin
      m <<= 1;
      for (int i = 0; i < 3; i++) mag[i] <<= 1;
    end
    len2 = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
    if (len2 < 64'd1 << 62) begin
      len2 <<= 2;
      s = 1;
    end
    y = 64'(RS_SEED[len2[63:60]]) << 15;
    x = len2 >> 34;
    for (int k = 0; k < STEPS; k++) begin
      y2 = (y * y) >> 30;
      t = (x * y2) >> 30;
      f = (t >= (64'd3 << 30)) ? 64'd0 : (64'd3 << 30) - t;
      y = (y * f) >> 31;
    end
    lim = 64'd1 << FRAC_BITS;
    for (int i = 0; i < 3; i++) begin
      p = (mag[i] * y) << s;
      r = (p + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS);
      if (r > lim) r = lim;
      o[i] = neg[i] ? -longint'(r) : longint'(r);
    end
    return 0;
  endfunction

  // Build the tangent frame and bend the normal by the perturbation word
  function automatic bent_normal_t bend_normal(input longint n[3], input longint u,
                                               input longint v, input longint w);
    longint t[3], tan_v[3], tan_u[3], acc[3], res[3];
    longint nz_lim;
    bit bad;
    bent_normal_t b;
    nz_lim = (longint'(99) << FRAC_BITS) / 100;
    if (n[2] > nz_lim || n[2] < -nz_lim) begin
      t[0] = 0; t[1] = -n[2]; t[2] = n[1];
    end else begin
      t[0] = n[1]; t[1] = -n[0]; t[2] = 0;
    end
    bad = to_unit(t, tan_v);
    t[0] = n[1] * tan_v[2] - n[2] * tan_v[1];
    t[1] = n[2] * tan_v[0] - n[0] * tan_v[2];
    t[2] = n[0] * tan_v[1] - n[1] * tan_v[0];
    bad |= to_unit(t, tan_u);
    for (int i = 0; i < 3; i++)
      acc[i] = n[i] * ((longint'(1) << PERT_FRAC) + w) + tan_u[i] * u + tan_v[i] * v;
    bad |= to_unit(acc, res);
    if (bad) for (int i = 0; i < 3; i++) res[i] = 0;
    b.x = res[0][15:0];
    b.y = res[1][15:0];
    b.z = res[2][15:0];
    b.degen = bad;
    return b;
  endfunction

  assign pending = bent_q.size();

  // Predict on input words, compare on result words
  always @(posedge clk) begin
    longint n[3];
    bent_normal_t exp_b;
    if (!rst_n) begin
      errors <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        n[0] = in_normal_x; n[1] = in_normal_y; n[2] = in_normal_z;
        bent_q.push_back(bend_normal(n, in_perturb_u, in_perturb_v, in_perturb_w));
      end
      if (out_valid && !out_stall) begin
        if (bent_q.size() == 0) begin
          $error("unexpected result word");
          errors <= errors + 1;
        end else begin
          exp_b = bent_q.pop_front();
          if (out_x !== exp_b.x || out_y !== exp_b.y || out_z !== exp_b.z ||
              out_degenerate !== exp_b.degen) begin
            if (out_x !== exp_b.x) $error("out_x exp %0d got %0d", $signed(exp_b.x), out_x);
            if (out_y !== exp_b.y) $error("out_y exp %0d got %0d", $signed(exp_b.y), out_y);
            if (out_z !== exp_b.z) $error("out_z exp %0d got %0d", $signed(exp_b.z), out_z);
            if (out_degenerate !== exp_b.degen)
              $error("out_degenerate exp %0b got %0b", exp_b.degen, out_degenerate);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

/* sim/tangent_frame_normal_perturb_unit_test.sv */
`timescale 1ns / 1ps
module tangent_frame_normal_perturb_unit_test;
  import tfn_pkg::*;

  localparam int LATENCY   = 3 * (7 + 4 * 3) + 6;
  localparam int WDOG_MAX  = 2000;
  localparam int N_RANDOM  = 1130;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic signed [15:0] in_normal_x = 0, in_normal_y = 0, in_normal_z = 0;
  logic signed [15:0] in_perturb_u = 0, in_perturb_v = 0, in_perturb_w = 0;
  logic out_valid;
  logic out_stall = 1;
  logic signed [15:0] out_x, out_y, out_z;
  logic out_degenerate;
  int errors, pending;
  int idle_cycles = 0;
  bit hold_out = 0;

  always #5 clk = ~clk;

  tangent_frame_normal_perturb_unit i_dut (.*);

  tfn_checker i_checker (.*);

  // Short gaps mostly, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Pick a normal component: edges, near-threshold or random
  function automatic logic [15:0] pick_normal();
    case ($urandom_range(0, 9))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'(16'sd16220 + $urandom_range(0, 4));
      3: return 16'(-16'sd16220 - $urandom_range(0, 4));
      4: return 16'h8000;
      5: return 16'd0;
      6: return 16'($urandom());
      default: return 16'($urandom_range(0, 32768) - 16384);
    endcase
  endfunction

  // Drive one word and wait for it to be taken
  task automatic send_word(input logic [15:0] nx, ny, nz, pu, pv, pw);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    in_normal_x <= nx; in_normal_y <= ny; in_normal_z <= nz;
    in_perturb_u <= pu; in_perturb_v <= pv; in_perturb_w <= pw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Receiver stalls: random, with stall-free stretches
  always @(posedge clk) begin
    if (hold_out) out_stall <= 0;
    else out_stall <= ($urandom_range(0, 99) < 30) ? ($urandom_range(0, 9) == 0) | 1'b1
                                                   : 1'b0;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic [15:0] v16;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // Edge cases: zero normal, axis normals, threshold on nz, extreme weights
    send_word(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_word(16'd16384, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_word(16'd0, 16'd16384, 16'd0, 16'h7fff, 16'd0, 16'd0);
    send_word(16'd0, 16'd0, 16'd16384, 16'd0, 16'h7fff, 16'd0);
    send_word(16'd0, 16'd0, -16'sd16384, 16'h8000, 16'h8000, 16'd0);
    send_word(16'd0, 16'd0, 16'd16219, 16'd100, 16'd200, 16'd300);
    send_word(16'd0, 16'd0, 16'd16220, 16'd100, 16'd200, 16'd300);
    send_word(16'd0, 16'd0, -16'sd16220, 16'd100, 16'd200, 16'd300);
    send_word(16'd0, 16'd0, -16'sd16219, 16'd100, 16'd200, 16'd300);
    send_word(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_word(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_word(16'd0, 16'd0, 16'd16384, 16'd0, 16'd0, 16'd0);
    send_word(16'd8000, 16'd8000, 16'd8000, 16'd0, 16'd0, 16'hf000);
    send_word(16'd8000, -16'sd8000, 16'd5000, 16'd0, 16'd0, 16'h8000);
    send_word(16'd11585, 16'd11585, 16'd0, 16'hffff, 16'd1, 16'h1000);
    send_word(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    in_valid <= 0;
    // Wait for the pipeline to drain before random traffic
    hold_out = 1;
    while (pending != 0) @(posedge clk);
    hold_out = 0;
    for (int i = 0; i < N_RANDOM; i++) begin
      v16 = (i % 7 == 0) ? 16'($urandom()) : 16'($urandom_range(0, 8191) - 4096);
      send_word(pick_normal(), pick_normal(), pick_normal(),
                16'($urandom()), 16'($urandom()), v16);
    end
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
